// ----- design/srlp_pkg.sv -----
// Package for the secant root finder: fixed-point constants, status codes,
// controller/datapath command and status structs. No dependencies.
package srlp_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned LimitW = 11;
  localparam int unsigned TolW   = 31;
  localparam int unsigned QFrac  = 24;
  localparam int unsigned MaxNodes = 4;
  localparam int unsigned NodeIdxW = 2;
  localparam int unsigned RegIdxW  = 3;

  localparam logic [1:0] StatusConverged = 2'd0;
  localparam logic [1:0] StatusLimit     = 2'd1;
  localparam logic [1:0] StatusZeroDiv   = 2'd2;

  localparam logic signed [DataW-1:0] QOne = 32'sd16777216;

  localparam logic signed [DataW-1:0] NodeXReset [MaxNodes] = '{
    32'sd5033165, 32'sd6710886, 32'sd8388608, 32'sd10066330};
  localparam logic signed [DataW-1:0] NodeYReset [MaxNodes] = '{
    -32'sd7395699, -32'sd4535217, -32'sd1787293, 32'sd858792};

  // datapath micro-operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,      // latch start values
    OP_ACC_CLR,   // acc = 0, select point
    OP_TERM_INIT, // term = one
    OP_DIV_Q,     // start (t - xj) << 24 / (xi - xj)
    OP_MUL_TERM,  // term = sat(term * q >> 24)
    OP_MUL_Y,     // acc = sat(acc + sat(term * yi >> 24))
    OP_SAVE_F,    // save acc as fc or fp
    OP_DIV_STEP,  // start fc * diff / d
    OP_UPDATE     // next, compare, shift guesses
  } dp_op_e;

  typedef struct packed {
    dp_op_e                 op;
    logic                   sel_prev;  // evaluate at prev
    logic [NodeIdxW-1:0]    i;
    logic [NodeIdxW-1:0]    j;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic den_zero;  // xi == xj for current i, j
    logic d_zero;    // fc == fp
    logic conv;      // last update converged
  } dp_status_t;

  function automatic logic signed [DataW-1:0] sat64(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sd2147483647;
    lo = -66'sd2147483648;
    if (v > hi) return 32'sh7fffffff;
    else if (v < lo) return 32'sh80000000;
    else return v[DataW-1:0];
  endfunction

endpackage

// ----- design/srlp_div.sv -----
// Iterative signed divider, one quotient bit per cycle, truncating toward
// zero. Uses srlp_pkg.
module srlp_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [65:0]  num_i,
  input  logic signed [65:0]  den_i,
  output logic                busy_o,
  output logic signed [65:0]  quo_o
);
  import srlp_pkg::*;

  logic [6:0]  cnt_q, cnt_d;
  logic [65:0] rem_q, rem_d;
  logic [65:0] quo_q, quo_d;
  logic [65:0] dv_q, dv_d;
  logic        neg_q, neg_d;
  logic [66:0] trial;

  assign trial = {rem_q, quo_q[65]} - {1'b0, dv_q};

  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    dv_d  = dv_q;
    neg_d = neg_q;
    if (start_i) begin
      cnt_d = 7'd66;
      rem_d = '0;
      quo_d = num_i[65] ? 66'(-num_i) : num_i;
      dv_d  = den_i[65] ? 66'(-den_i) : den_i;
      neg_d = num_i[65] ^ den_i[65];
    end else if (cnt_q != 7'd0) begin
      cnt_d = cnt_q - 7'd1;
      if (!trial[66]) begin
        rem_d = trial[65:0];
        quo_d = {quo_q[64:0], 1'b1};
      end else begin
        rem_d = {rem_q[64:0], quo_q[65]};
        quo_d = {quo_q[64:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dv_q  <= dv_d;
    neg_q <= neg_d;
  end

  assign busy_o = (cnt_q != 7'd0);
  assign quo_o  = neg_q ? 66'(-quo_q) : quo_q;

endmodule

// ----- design/srlp_datapath.sv -----
// Datapath: guess registers, interpolant accumulator, multiplier and
// shared divider. Uses srlp_pkg and srlp_div.
module srlp_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  srlp_pkg::dp_cmd_t                 cmd_i,
  input  logic signed [srlp_pkg::DataW-1:0] node_x_i [srlp_pkg::MaxNodes],
  input  logic signed [srlp_pkg::DataW-1:0] node_y_i [srlp_pkg::MaxNodes],
  input  logic signed [srlp_pkg::DataW-1:0] start_prev_i,
  input  logic signed [srlp_pkg::DataW-1:0] start_curr_i,
  input  logic [srlp_pkg::TolW-1:0]         tolerance_i,
  output srlp_pkg::dp_status_t              status_o,
  output logic signed [srlp_pkg::DataW-1:0] curr_o
);
  import srlp_pkg::*;

  logic signed [DataW-1:0] prev_q, curr_q, term_q, acc_q, fc_q, fp_q;
  logic [TolW-1:0]         tol_q;
  logic                    conv_q;
  logic signed [DataW-1:0] t, xi, xj, yi;
  logic signed [32:0]      den, dd;
  logic signed [65:0]      div_num, div_den, quo, prod;
  logic                    div_start, div_busy;
  logic signed [DataW-1:0] q_sat, mul_a, mul_b, diff, nxt;
  logic signed [32:0]      gap;
  logic [32:0]             gap_abs;
  logic signed [65:0]      mt;

  assign t  = cmd_i.sel_prev ? prev_q : curr_q;
  assign xi = node_x_i[cmd_i.i];
  assign xj = node_x_i[cmd_i.j];
  assign yi = node_y_i[cmd_i.i];
  assign den = 33'(xi) - 33'(xj);
  assign dd  = 33'(fc_q) - 33'(fp_q);
  assign diff = sat64(66'(curr_q) - 66'(prev_q));

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = 66'sd1;
    if (cmd_i.op == OP_DIV_Q) begin
      div_start = 1'b1;
      div_num   = (66'(t) - 66'(xj)) <<< QFrac;
      div_den   = 66'(den);
    end else if (cmd_i.op == OP_DIV_STEP) begin
      div_start = 1'b1;
      div_num   = 66'(fc_q) * 66'(diff);
      div_den   = 66'(dd);
    end
  end

  srlp_div u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .busy_o(div_busy), .quo_o(quo)
  );

  assign q_sat = sat64(quo);
  assign mul_a = term_q;
  assign mul_b = (cmd_i.op == OP_MUL_Y) ? yi : q_sat;
  assign prod  = 66'(mul_a) * 66'(mul_b);
  assign mt    = prod / 66'sd16777216;
  assign nxt   = sat64(66'(curr_q) - 66'(q_sat));
  assign gap   = 33'(nxt) - 33'(curr_q);
  assign gap_abs = gap[32] ? 33'(-gap) : gap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conv_q <= 1'b0;
    end else if (cmd_i.op == OP_UPDATE) begin
      conv_q <= gap_abs < {2'b0, tol_q};
    end else if (cmd_i.op == OP_LOAD) begin
      conv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        prev_q <= start_prev_i;
        curr_q <= start_curr_i;
        tol_q  <= tolerance_i;
      end
      OP_ACC_CLR:   acc_q  <= '0;
      OP_TERM_INIT: term_q <= QOne;
      OP_MUL_TERM:  term_q <= sat64(mt);
      OP_MUL_Y:     acc_q  <= sat64(66'(acc_q) + 66'(sat64(mt)));
      OP_SAVE_F: begin
        if (cmd_i.sel_prev) fp_q <= acc_q;
        else fc_q <= acc_q;
      end
      OP_UPDATE: begin
        prev_q <= curr_q;
        curr_q <= nxt;
      end
      default: ;
    endcase
  end

  assign status_o.div_busy = div_busy;
  assign status_o.den_zero = (den == 33'sd0);
  assign status_o.d_zero   = (dd == 33'sd0);
  assign status_o.conv     = conv_q;
  assign curr_o            = curr_q;

endmodule

// ----- design/srlp_ctrl.sv -----
// Controller: sequences interpolant evaluations and secant updates, counts
// iterations, forms the result. Uses srlp_pkg.
module srlp_ctrl #(
  parameter int unsigned NODES = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [srlp_pkg::LimitW-1:0]       iteration_limit_i,
  input  srlp_pkg::dp_status_t              dp_i,
  input  logic signed [srlp_pkg::DataW-1:0] curr_i,
  output srlp_pkg::dp_cmd_t                 cmd_o,
  output logic                              busy_o,
  output logic                              done_o,
  output logic signed [srlp_pkg::DataW-1:0] root_o,
  output logic [srlp_pkg::LimitW-1:0]       iterations_used_o,
  output logic [1:0]                        status_o
);
  import srlp_pkg::*;

  localparam logic [NodeIdxW-1:0] LastNode = NodeIdxW'(NODES - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_ITER, S_ACC, S_TERM, S_CHKJ, S_DIVW, S_MULT, S_MULY,
    S_SAVE, S_DCHK, S_SDIVW, S_UPD, S_TEST, S_DONE
  } state_e;

  state_e              state_q;
  logic [LimitW-1:0]   limit_q, used_q;
  logic                side_q;
  logic [NodeIdxW-1:0] i_q, j_q;
  logic                go;

  assign go = start_i && !busy_o;
  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o.sel_prev = side_q;
    cmd_o.i = i_q;
    cmd_o.j = j_q;
    cmd_o.op = OP_NONE;
    if (go) cmd_o.op = OP_LOAD;
    else begin
      unique case (state_q)
        S_ACC:  cmd_o.op = OP_ACC_CLR;
        S_TERM: cmd_o.op = OP_TERM_INIT;
        S_CHKJ: if (j_q != i_q && !dp_i.den_zero) cmd_o.op = OP_DIV_Q;
        S_MULT: cmd_o.op = OP_MUL_TERM;
        S_MULY: cmd_o.op = OP_MUL_Y;
        S_SAVE: cmd_o.op = OP_SAVE_F;
        S_DCHK: if (!dp_i.d_zero) cmd_o.op = OP_DIV_STEP;
        S_UPD:  cmd_o.op = OP_UPDATE;
        default: cmd_o.op = OP_NONE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      limit_q <= '0;
      used_q  <= '0;
      side_q  <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      done_o  <= 1'b0;
      root_o  <= '0;
      iterations_used_o <= '0;
      status_o <= StatusLimit;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        S_IDLE: if (go) begin
          limit_q <= iteration_limit_i;
          used_q  <= '0;
          state_q <= S_ITER;
        end
        S_ITER: begin
          if (used_q == limit_q) begin
            status_o <= StatusLimit;
            root_o   <= '0;
            state_q  <= S_DONE;
          end else begin
            used_q  <= used_q + 1'b1;
            side_q  <= 1'b0;
            state_q <= S_ACC;
          end
        end
        S_ACC: begin
          i_q <= '0;
          state_q <= S_TERM;
        end
        S_TERM: begin
          j_q <= '0;
          state_q <= S_CHKJ;
        end
        S_CHKJ: begin
          if (j_q == i_q) begin
            if (j_q == LastNode) state_q <= S_MULY;
            else j_q <= j_q + 1'b1;
          end else if (dp_i.den_zero) begin
            status_o <= StatusZeroDiv;
            root_o   <= '0;
            state_q  <= S_DONE;
          end else state_q <= S_DIVW;
        end
        S_DIVW: if (!dp_i.div_busy) state_q <= S_MULT;
        S_MULT: begin
          if (j_q == LastNode) state_q <= S_MULY;
          else begin
            j_q <= j_q + 1'b1;
            state_q <= S_CHKJ;
          end
        end
        S_MULY: begin
          if (i_q == LastNode) state_q <= S_SAVE;
          else begin
            i_q <= i_q + 1'b1;
            state_q <= S_TERM;
          end
        end
        S_SAVE: begin
          if (side_q) state_q <= S_DCHK;
          else begin
            side_q <= 1'b1;
            state_q <= S_ACC;
          end
        end
        S_DCHK: begin
          if (dp_i.d_zero) begin
            status_o <= StatusZeroDiv;
            root_o   <= '0;
            state_q  <= S_DONE;
          end else state_q <= S_SDIVW;
        end
        S_SDIVW: if (!dp_i.div_busy) state_q <= S_UPD;
        S_UPD: state_q <= S_TEST;
        S_TEST: begin
          if (dp_i.conv) begin
            status_o <= StatusConverged;
            root_o   <= curr_i;
            state_q  <= S_DONE;
          end else state_q <= S_ITER;
        end
        S_DONE: begin
          iterations_used_o <= used_q;
          done_o  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_used_le_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> used_q <= limit_q) else $error("iteration count above limit");
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");
  a_root_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != StatusConverged |-> root_o == '0)
    else $error("nonzero root without convergence");
`endif

endmodule

// ----- design/secant_root_of_lagrange_poly_core.sv -----
// Top level: secant root finder on a Lagrange interpolant, APB node
// registers. Uses srlp_pkg, srlp_ctrl, srlp_datapath.
//
// channel | handshake          | payload
// input   | start, busy        | start_prev_i start_curr_i tolerance_i iteration_limit_i
// result  | done_o (1 cycle)   | root_o iterations_used_o status_o
// config  | psel/penable/pwrite| paddr (8 regs at 4*i), pwdata, prdata
//
// Each iteration runs two interpolant evaluations of NODES*(NODES-1)
// divides each, plus one step divide. Reset loads the default nodes.
// The receiver cannot stall; busy holds off new transactions until the
// result strobe.
module secant_root_of_lagrange_poly_core #(
  parameter int unsigned NODES = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [srlp_pkg::DataW-1:0]   start_prev_i,
  input  logic signed [srlp_pkg::DataW-1:0]   start_curr_i,
  input  logic [srlp_pkg::TolW-1:0]           tolerance_i,
  input  logic [srlp_pkg::LimitW-1:0]         iteration_limit_i,
  output logic                                done_o,
  output logic signed [srlp_pkg::DataW-1:0]   root_o,
  output logic [srlp_pkg::LimitW-1:0]         iterations_used_o,
  output logic [1:0]                          status_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [4:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import srlp_pkg::*;

  logic signed [DataW-1:0] node_x_q [MaxNodes];
  logic signed [DataW-1:0] node_y_q [MaxNodes];
  dp_cmd_t                 cmd;
  dp_status_t              dps;
  logic signed [DataW-1:0] curr;
  logic [RegIdxW-1:0]      ridx;

  assign pready = 1'b1;
  assign ridx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_x_q <= NodeXReset;
      node_y_q <= NodeYReset;
    end else if (psel && penable && pwrite) begin
      if (ridx[2]) node_y_q[ridx[1:0]] <= pwdata;
      else node_x_q[ridx[1:0]] <= pwdata;
    end
  end

  assign prdata = ridx[2] ? node_y_q[ridx[1:0]] : node_x_q[ridx[1:0]];

  srlp_ctrl #(.NODES(NODES)) u_ctrl (
    .clk_i, .rst_ni,
    .start_i(start), .iteration_limit_i,
    .dp_i(dps), .curr_i(curr), .cmd_o(cmd),
    .busy_o(busy), .done_o, .root_o, .iterations_used_o, .status_o
  );

  srlp_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .node_x_i(node_x_q), .node_y_i(node_y_q),
    .start_prev_i, .start_curr_i, .tolerance_i,
    .status_o(dps), .curr_o(curr)
  );

endmodule
